### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition in the next cycle follows from a condition now.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/mru_pkg.sv
// ----------------------------------------------------------------------------
// mru_pkg
// Types, constants and saturating helpers of the moment relaxation update.
// ----------------------------------------------------------------------------
package mru_pkg;

   // internal word: signed fixed point, 64 bits
   localparam int IW = 64;

   typedef logic signed [IW-1:0] ival_type;

   localparam ival_type IMAX = {1'b0, {(IW-1){1'b1}}};
   localparam ival_type IMIN = {1'b1, {(IW-1){1'b0}}};

   // value with its clip flag
   typedef struct packed {
      logic     sat;
      ival_type val;
   } satval_type;

   // all values that travel down the pipeline with one word
   typedef struct packed {
      logic     sat;
      ival_type m0, m1, m2, m3, m4, e;
      ival_type z2, a, zm1, s;
      ival_type z3, a2, c2, t2, n1, z2m2, as3, ss3, t3a;
      ival_type z4, a3, c3, t3c, n2a, c2m0, a2s6, t6c, t4a, n3a;
      ival_type n2;
      ival_type c4a, t4c, c3m0, n3b, n4a, t6cm2;
      ival_type n3, c4, n4b;
      ival_type n4c, c4m0;
      ival_type n4;
   } slot_type;

   // saturating add
   function automatic satval_type sat_add(ival_type x, ival_type y);
      logic [IW:0] w;
      satval_type  r;
      w     = {x[IW-1], x} + {y[IW-1], y};
      r.sat = w[IW] ^ w[IW-1];
      r.val = r.sat ? (w[IW] ? IMIN : IMAX) : ival_type'(w[IW-1:0]);
      return r;
   endfunction

   // saturating small multiple: 2, 3, 4 or 6 times x; any other k gives x itself
   function automatic satval_type sat_mul_k(ival_type x, logic [2:0] k);
      logic [IW+2:0] xe;
      logic [IW+2:0] w;
      logic          ovf;
      satval_type    r;
      xe = {{3{x[IW-1]}}, x};
      case (k)
         3'd2: begin
            w = xe << 1;
         end
         3'd3: begin
            w = (xe << 1) + xe;
         end
         3'd4: begin
            w = xe << 2;
         end
         3'd6: begin
            w = (xe << 2) + (xe << 1);
         end
         default: begin
            w = xe;
         end
      endcase
      ovf   = (w[IW+2:IW-1] != '0) && (w[IW+2:IW-1] != '1);
      r.sat = ovf;
      r.val = ovf ? (w[IW+2] ? IMIN : IMAX) : ival_type'(w[IW-1:0]);
      return r;
   endfunction

endpackage

### rtl/mru_qmul.sv
// ----------------------------------------------------------------------------
// mru_qmul
// Four-stage fixed point multiplier: 64x64 signed from 32x32 partial
// products, round half up, shift by the fraction bits, saturate.
// ----------------------------------------------------------------------------
module mru_qmul #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              en,
   input  mru_pkg::ival_type op_a,
   input  mru_pkg::ival_type op_b,
   output mru_pkg::ival_type result,
   output logic              ovf
);
   import mru_pkg::*;

   localparam int HW = IW / 2;
   localparam int PW = 2 * IW;
   localparam logic [IW-1:0] HALF = IW'(1) << (FRAC_BITS - 1);
   localparam logic [IW-1:0] LIM_POS = {1'b0, {(IW-1){1'b1}}};
   localparam logic [IW-1:0] LIM_NEG = {1'b1, {(IW-1){1'b0}}};

   logic          neg1_ff, neg2_ff, neg3_ff;
   logic [IW-1:0] ua_ff, ub_ff;
   logic [IW-1:0] p00_ff, p01_ff, p10_ff, p11_ff;
   logic [PW-1:0] sum_ff, sum_in;
   logic [PW-1:0] q;
   logic          big;
   ival_type      y_ff, y_in;
   logic          ovf_ff;

   // sum partial products with the rounding bias
   always_comb begin
      sum_in = {{IW{1'b0}}, p00_ff}
             + {{HW{1'b0}}, p01_ff, {HW{1'b0}}}
             + {{HW{1'b0}}, p10_ff, {HW{1'b0}}}
             + {p11_ff, {IW{1'b0}}}
             + {{IW{1'b0}}, (neg2_ff ? HALF - IW'(1) : HALF)};
   end

   // shift, range check and apply the sign
   always_comb begin
      q   = sum_ff >> FRAC_BITS;
      big = (q[PW-1:IW] != '0) || (q[IW-1:0] > (neg3_ff ? LIM_NEG : LIM_POS));
      if (big) begin
         y_in = neg3_ff ? IMIN : IMAX;
      end else begin
         y_in = neg3_ff ? ival_type'(-q[IW-1:0]) : ival_type'(q[IW-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg1_ff <= op_a[IW-1] ^ op_b[IW-1];
         ua_ff   <= op_a[IW-1] ? -op_a : op_a;
         ub_ff   <= op_b[IW-1] ? -op_b : op_b;
         neg2_ff <= neg1_ff;
         p00_ff  <= ua_ff[HW-1:0]  * ub_ff[HW-1:0];
         p01_ff  <= ua_ff[HW-1:0]  * ub_ff[IW-1:HW];
         p10_ff  <= ua_ff[IW-1:HW] * ub_ff[HW-1:0];
         p11_ff  <= ua_ff[IW-1:HW] * ub_ff[IW-1:HW];
         neg3_ff <= neg2_ff;
         sum_ff  <= sum_in;
         y_ff    <= y_in;
         ovf_ff  <= big;
      end
   end

   assign result = y_ff;
   assign ovf    = ovf_ff;

endmodule

### rtl/moment_relaxation_update_unit.sv
// ----------------------------------------------------------------------------
// moment_relaxation_update_unit
// Relaxes moments one to four of a quadrature point over one time step with
// the loaded decay factor; moment zero passes through. Results saturate.
// ----------------------------------------------------------------------------
//   channel   dir  handshake             contents
//   req_      in   tvalid/tready         moment0..4, field_value
//   rsp_      out  tvalid/tready         new_moment0..4, saturated (tuser)
//   csr_      in   wr_en                 decay_factor
//
// One word per cycle while the output is not stalled; 30 register stages: an
// input register, five dependent levels of four-stage multipliers with one or
// two add stages after each, and a clip.
// Reset clears the valid bits and loads a decay factor of one.
// A stall at the output holds every stage at once, so nothing is lost.
`include "assert_macros.svh"

module moment_relaxation_update_unit #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [FRAC_BITS:0]                   csr_wr_data,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // moment0, moment1, moment2, moment3, moment4, field_value
   input  logic [((6*DATA_WIDTH+7)/8)*8-1:0]    req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // new_moment0, new_moment1, new_moment2, new_moment3, new_moment4
   output logic [((5*DATA_WIDTH+7)/8)*8-1:0]    rsp_tdata,
   // saturated
   output logic [0:0]                           rsp_tuser
);
   import mru_pkg::*;

   localparam int DW    = DATA_WIDTH;
   localparam int ZW    = FRAC_BITS + 1;
   localparam int NST   = 30;
   localparam int NQ    = 30;

   localparam logic [ZW-1:0] ONE_Z = ZW'(1) << FRAC_BITS;
   localparam ival_type ONE_I   = ival_type'(IW'(1) << FRAC_BITS);
   localparam ival_type OUT_MAX = IMAX >>> (IW - DW);
   localparam ival_type OUT_MIN = IMIN >>> (IW - DW);

   // multiplier slots, by level
   localparam int Q_Z2 = 0, Q_A = 1, Q_ZM1 = 2;
   localparam int Q_Z3 = 3, Q_A2 = 4, Q_ZA = 5, Q_AM0 = 6, Q_Z2M2 = 7;
   localparam int Q_AS = 8, Q_SS = 9, Q_Z2A = 10;
   localparam int Q_Z4 = 11, Q_A3 = 12, Q_ZC2 = 13, Q_Z3M3 = 14, Q_T2M1 = 15;
   localparam int Q_C2M0 = 16, Q_A2S = 17, Q_Z2C2 = 18, Q_Z3A = 19, Q_T3AM2 = 20;
   localparam int Q_A4 = 21, Q_ZC3 = 22, Q_C3M0 = 23, Q_T3CM1 = 24;
   localparam int Q_T6CM2 = 25, Q_T4AM3 = 26, Q_Z4M4 = 27;
   localparam int Q_T4CM1 = 28, Q_C4M0 = 29;

   logic [ZW-1:0]  decay_ff;
   ival_type       z_val, zmo;
   logic [NST-1:0] valid_ff;
   logic           pipe_en;
   slot_type       st_ff [NST];
   slot_type       st_in [NST];
   ival_type       qa [NQ];
   ival_type       qb [NQ];
   ival_type       qy [NQ];
   logic           qs [NQ];

   function automatic satval_type clip_out(ival_type v);
      satval_type r;
      r.sat = (v > OUT_MAX) || (v < OUT_MIN);
      r.val = (v > OUT_MAX) ? OUT_MAX : ((v < OUT_MIN) ? OUT_MIN : v);
      return r;
   endfunction

   // decay factor register
   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff <= ONE_Z;
      end else if (csr_wr_en) begin
         decay_ff <= csr_wr_data;
      end
   end

   // clamp Z to one
   always_comb begin
      z_val = (decay_ff > ONE_Z) ? ONE_I : ival_type'({{(IW-ZW){1'b0}}, decay_ff});
      zmo   = z_val - ONE_I;
   end

   // advance whenever the output word is empty or taken
   assign pipe_en    = !valid_ff[NST-1] || rsp_tready;
   assign req_tready = pipe_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (pipe_en) begin
         valid_ff <= {valid_ff[NST-2:0], req_tvalid};
      end
   end

   // multiplier operands
   always_comb begin
      qa[Q_Z2]    = z_val;           qb[Q_Z2]    = z_val;
      qa[Q_A]     = st_ff[0].e;      qb[Q_A]     = zmo;
      qa[Q_ZM1]   = z_val;           qb[Q_ZM1]   = st_ff[0].m1;
      qa[Q_Z3]    = st_ff[5].z2;     qb[Q_Z3]    = z_val;
      qa[Q_A2]    = st_ff[5].a;      qb[Q_A2]    = st_ff[5].a;
      qa[Q_ZA]    = z_val;           qb[Q_ZA]    = st_ff[5].a;
      qa[Q_AM0]   = st_ff[5].a;      qb[Q_AM0]   = st_ff[5].m0;
      qa[Q_Z2M2]  = st_ff[5].z2;     qb[Q_Z2M2]  = st_ff[5].m2;
      qa[Q_AS]    = st_ff[5].a;      qb[Q_AS]    = st_ff[5].s;
      qa[Q_SS]    = st_ff[5].s;      qb[Q_SS]    = st_ff[5].s;
      qa[Q_Z2A]   = st_ff[5].z2;     qb[Q_Z2A]   = st_ff[5].a;
      qa[Q_Z4]    = st_ff[10].z3;    qb[Q_Z4]    = z_val;
      qa[Q_A3]    = st_ff[10].a2;    qb[Q_A3]    = st_ff[10].a;
      qa[Q_ZC2]   = z_val;           qb[Q_ZC2]   = st_ff[10].c2;
      qa[Q_Z3M3]  = st_ff[10].z3;    qb[Q_Z3M3]  = st_ff[10].m3;
      qa[Q_T2M1]  = st_ff[10].t2;    qb[Q_T2M1]  = st_ff[10].m1;
      qa[Q_C2M0]  = st_ff[10].c2;    qb[Q_C2M0]  = st_ff[10].m0;
      qa[Q_A2S]   = st_ff[10].a2;    qb[Q_A2S]   = st_ff[10].s;
      qa[Q_Z2C2]  = st_ff[10].z2;    qb[Q_Z2C2]  = st_ff[10].c2;
      qa[Q_Z3A]   = st_ff[10].z3;    qb[Q_Z3A]   = st_ff[10].a;
      qa[Q_T3AM2] = st_ff[10].t3a;   qb[Q_T3AM2] = st_ff[10].m2;
      qa[Q_A4]    = st_ff[16].a3;    qb[Q_A4]    = st_ff[16].a;
      qa[Q_ZC3]   = z_val;           qb[Q_ZC3]   = st_ff[16].c3;
      qa[Q_C3M0]  = st_ff[16].c3;    qb[Q_C3M0]  = st_ff[16].m0;
      qa[Q_T3CM1] = st_ff[16].t3c;   qb[Q_T3CM1] = st_ff[16].m1;
      qa[Q_T6CM2] = st_ff[16].t6c;   qb[Q_T6CM2] = st_ff[16].m2;
      qa[Q_T4AM3] = st_ff[16].t4a;   qb[Q_T4AM3] = st_ff[16].m3;
      qa[Q_Z4M4]  = st_ff[16].z4;    qb[Q_Z4M4]  = st_ff[16].m4;
      qa[Q_T4CM1] = st_ff[22].t4c;   qb[Q_T4CM1] = st_ff[22].m1;
      qa[Q_C4M0]  = st_ff[22].c4;    qb[Q_C4M0]  = st_ff[22].m0;
   end

   for (genvar g = 0; g < NQ; g++) begin : g_qmul
      mru_qmul #(
         .FRAC_BITS (FRAC_BITS)
      ) u_qmul (
         .clock  (clock),
         .en     (pipe_en),
         .op_a   (qa[g]),
         .op_b   (qb[g]),
         .result (qy[g]),
         .ovf    (qs[g])
      );
   end

   // next value of every stage
   always_comb begin
      satval_type r;

      // capture the input word
      st_in[0]     = '0;
      st_in[0].m0  = ival_type'(signed'(req_tdata[0*DW +: DW]));
      st_in[0].m1  = ival_type'(signed'(req_tdata[1*DW +: DW]));
      st_in[0].m2  = ival_type'(signed'(req_tdata[2*DW +: DW]));
      st_in[0].m3  = ival_type'(signed'(req_tdata[3*DW +: DW]));
      st_in[0].m4  = ival_type'(signed'(req_tdata[4*DW +: DW]));
      st_in[0].e   = ival_type'(signed'(req_tdata[5*DW +: DW]));

      // carry everything forward by default
      for (int j = 1; j < NST; j++) begin
         st_in[j] = st_ff[j-1];
      end

      // first level: Z^2, a, Z*M1
      st_in[5].z2  = qy[Q_Z2];
      st_in[5].a   = qy[Q_A];
      st_in[5].zm1 = qy[Q_ZM1];
      st_in[5].s   = ONE_I - qy[Q_Z2];
      st_in[5].sat = st_ff[4].sat | qs[Q_Z2] | qs[Q_A] | qs[Q_ZM1];

      // second level and its sums
      st_in[10].z3   = qy[Q_Z3];
      st_in[10].a2   = qy[Q_A2];
      st_in[10].z2m2 = qy[Q_Z2M2];
      st_in[10].sat  = st_ff[9].sat | qs[Q_Z3] | qs[Q_A2] | qs[Q_ZA] | qs[Q_AM0]
                     | qs[Q_Z2M2] | qs[Q_AS] | qs[Q_SS] | qs[Q_Z2A];
      r = sat_add(qy[Q_A2], st_ff[9].s);
      st_in[10].c2 = r.val;  st_in[10].sat = st_in[10].sat | r.sat;
      r = sat_mul_k(qy[Q_ZA], 3'd2);
      st_in[10].t2 = r.val;  st_in[10].sat = st_in[10].sat | r.sat;
      r = sat_add(st_ff[9].zm1, qy[Q_AM0]);
      st_in[10].n1 = r.val;  st_in[10].sat = st_in[10].sat | r.sat;
      r = sat_mul_k(qy[Q_AS], 3'd3);
      st_in[10].as3 = r.val; st_in[10].sat = st_in[10].sat | r.sat;
      r = sat_mul_k(qy[Q_SS], 3'd3);
      st_in[10].ss3 = r.val; st_in[10].sat = st_in[10].sat | r.sat;
      r = sat_mul_k(qy[Q_Z2A], 3'd3);
      st_in[10].t3a = r.val; st_in[10].sat = st_in[10].sat | r.sat;

      // third level and its sums
      st_in[15].z4   = qy[Q_Z4];
      st_in[15].a3   = qy[Q_A3];
      st_in[15].c2m0 = qy[Q_C2M0];
      st_in[15].sat  = st_ff[14].sat | qs[Q_Z4] | qs[Q_A3] | qs[Q_ZC2] | qs[Q_Z3M3]
                     | qs[Q_T2M1] | qs[Q_C2M0] | qs[Q_A2S] | qs[Q_Z2C2] | qs[Q_Z3A]
                     | qs[Q_T3AM2];
      r = sat_add(qy[Q_A3], st_ff[14].as3);
      st_in[15].c3 = r.val;   st_in[15].sat = st_in[15].sat | r.sat;
      r = sat_mul_k(qy[Q_ZC2], 3'd3);
      st_in[15].t3c = r.val;  st_in[15].sat = st_in[15].sat | r.sat;
      r = sat_add(st_ff[14].z2m2, qy[Q_T2M1]);
      st_in[15].n2a = r.val;  st_in[15].sat = st_in[15].sat | r.sat;
      r = sat_mul_k(qy[Q_A2S], 3'd6);
      st_in[15].a2s6 = r.val; st_in[15].sat = st_in[15].sat | r.sat;
      r = sat_mul_k(qy[Q_Z2C2], 3'd6);
      st_in[15].t6c = r.val;  st_in[15].sat = st_in[15].sat | r.sat;
      r = sat_mul_k(qy[Q_Z3A], 3'd4);
      st_in[15].t4a = r.val;  st_in[15].sat = st_in[15].sat | r.sat;
      r = sat_add(qy[Q_Z3M3], qy[Q_T3AM2]);
      st_in[15].n3a = r.val;  st_in[15].sat = st_in[15].sat | r.sat;

      // finish n2
      r = sat_add(st_ff[15].n2a, st_ff[15].c2m0);
      st_in[16].n2 = r.val;   st_in[16].sat = st_ff[15].sat | r.sat;

      // fourth level and its sums
      st_in[21].c3m0  = qy[Q_C3M0];
      st_in[21].t6cm2 = qy[Q_T6CM2];
      st_in[21].sat   = st_ff[20].sat | qs[Q_A4] | qs[Q_ZC3] | qs[Q_C3M0]
                      | qs[Q_T3CM1] | qs[Q_T6CM2] | qs[Q_T4AM3] | qs[Q_Z4M4];
      r = sat_add(qy[Q_A4], st_ff[20].a2s6);
      st_in[21].c4a = r.val;  st_in[21].sat = st_in[21].sat | r.sat;
      r = sat_mul_k(qy[Q_ZC3], 3'd4);
      st_in[21].t4c = r.val;  st_in[21].sat = st_in[21].sat | r.sat;
      r = sat_add(st_ff[20].n3a, qy[Q_T3CM1]);
      st_in[21].n3b = r.val;  st_in[21].sat = st_in[21].sat | r.sat;
      r = sat_add(qy[Q_Z4M4], qy[Q_T4AM3]);
      st_in[21].n4a = r.val;  st_in[21].sat = st_in[21].sat | r.sat;

      // second add step after the fourth level
      st_in[22].sat = st_ff[21].sat;
      r = sat_add(st_ff[21].n3b, st_ff[21].c3m0);
      st_in[22].n3 = r.val;   st_in[22].sat = st_in[22].sat | r.sat;
      r = sat_add(st_ff[21].c4a, st_ff[21].ss3);
      st_in[22].c4 = r.val;   st_in[22].sat = st_in[22].sat | r.sat;
      r = sat_add(st_ff[21].n4a, st_ff[21].t6cm2);
      st_in[22].n4b = r.val;  st_in[22].sat = st_in[22].sat | r.sat;

      // fifth level
      st_in[27].c4m0 = qy[Q_C4M0];
      st_in[27].sat  = st_ff[26].sat | qs[Q_T4CM1] | qs[Q_C4M0];
      r = sat_add(st_ff[26].n4b, qy[Q_T4CM1]);
      st_in[27].n4c = r.val;  st_in[27].sat = st_in[27].sat | r.sat;

      // finish n4
      r = sat_add(st_ff[27].n4c, st_ff[27].c4m0);
      st_in[28].n4 = r.val;   st_in[28].sat = st_ff[27].sat | r.sat;

      // clip to the output range
      st_in[29].sat = st_ff[28].sat;
      r = clip_out(st_ff[28].n1);
      st_in[29].n1 = r.val;   st_in[29].sat = st_in[29].sat | r.sat;
      r = clip_out(st_ff[28].n2);
      st_in[29].n2 = r.val;   st_in[29].sat = st_in[29].sat | r.sat;
      r = clip_out(st_ff[28].n3);
      st_in[29].n3 = r.val;   st_in[29].sat = st_in[29].sat | r.sat;
      r = clip_out(st_ff[28].n4);
      st_in[29].n4 = r.val;   st_in[29].sat = st_in[29].sat | r.sat;
   end

   // stage registers, held together on a stall
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int j = 0; j < NST; j++) begin
            st_ff[j] <= st_in[j];
         end
      end
   end

   // result word
   always_comb begin
      rsp_tdata            = '0;
      rsp_tdata[0*DW +: DW] = st_ff[NST-1].m0[DW-1:0];
      rsp_tdata[1*DW +: DW] = st_ff[NST-1].n1[DW-1:0];
      rsp_tdata[2*DW +: DW] = st_ff[NST-1].n2[DW-1:0];
      rsp_tdata[3*DW +: DW] = st_ff[NST-1].n3[DW-1:0];
      rsp_tdata[4*DW +: DW] = st_ff[NST-1].n4[DW-1:0];
      rsp_tuser            = st_ff[NST-1].sat;
   end

   assign rsp_tvalid = valid_ff[NST-1];

   // checks
   `ASSERT_NEXT(a_stall_holds, clock, reset, !pipe_en, $stable(valid_ff), "valid moved in stall")
   `ASSERT_NEXT(a_accept_enters, clock, reset, req_tvalid && req_tready, valid_ff[0], "lost word")
   `ASSERT_CLK(a_decay_clamped, clock, reset, (z_val <= ONE_I) && (zmo <= 0), "Z above one")

endmodule

### dv/tb_moment_relaxation_update_unit.sv
// ----------------------------------------------------------------------------
// tb_moment_relaxation_update_unit
// Streams quadrature points through the moment relaxation unit under several
// decay factors, predicts every relaxed word with a bit-exact fixed point
// model and compares the results in order, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_moment_relaxation_update_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DW      = 32;
   localparam int FB      = 16;
   localparam int LATENCY = 30;
   localparam longint ONE = 64'sd1 <<< FB;

   typedef logic [6*DW-1:0] point_word_type;

   typedef struct packed {
      logic [5*DW-1:0] moments;
      logic            sat;
   } relaxed_word_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_wr_en = 1'b0;
   logic [FB:0]       csr_wr_data = '0;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [6*DW-1:0]   req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [5*DW-1:0]   rsp_tdata;
   logic [0:0]        rsp_tuser;

   point_word_type    pending_points[$];
   relaxed_word_type  expected_words[$];
   logic [FB:0]       decay_mirror = 17'd65536;
   int                error_count = 0;
   bit                steady_mode = 1'b0;
   bit                word_taken = 1'b0;
   int                req_gap = 0;
   int                rsp_gap = 0;

   moment_relaxation_update_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // saturating 64-bit add
   function automatic longint fx_add(longint x, longint y, inout bit sat);
      logic signed [64:0] w;
      w = {x[63], x} + {y[63], y};
      if (w > 65'sh0_7fff_ffff_ffff_ffff) begin
         sat = 1'b1;
         return 64'h7fff_ffff_ffff_ffff;
      end
      if (w < -65'sh0_8000_0000_0000_0000) begin
         sat = 1'b1;
         return 64'h8000_0000_0000_0000;
      end
      return longint'(w[63:0]);
   endfunction

   // k times x by repeated saturating addition
   function automatic longint fx_times(longint x, int k, inout bit sat);
      longint r;
      r = x;
      for (int i = 1; i < k; i++) r = fx_add(r, x, sat);
      return r;
   endfunction

   // product in sign-magnitude, round half up in value (ties down on the magnitude of negative products), saturate
   function automatic longint fx_mul(longint x, longint y, inout bit sat);
      bit           neg;
      logic [63:0]  ux, uy;
      logic [128:0] p, q, lim;
      neg = (x < 0) != (y < 0);
      ux  = (x < 0) ? -x : x;
      uy  = (y < 0) ? -y : y;
      p   = {65'd0, ux} * {65'd0, uy};
      q   = (p + (neg ? ((1 << (FB-1)) - 1) : (1 << (FB-1)))) >> FB;
      lim = neg ? (129'd1 << 63) : ((129'd1 << 63) - 1);
      if (q > lim) begin
         sat = 1'b1;
         return neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
      end
      return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
   endfunction

   function automatic longint fx_clip(longint v, inout bit sat);
      if (v > 64'sd2147483647) begin
         sat = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         sat = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // relax one point with decay factor dz
   function automatic relaxed_word_type relax_point(point_word_type d, logic [FB:0] dz);
      bit               sat;
      longint           m0, m1, m2, m3, m4, e, z, z2, z3, z4, a, s, a2, a3, a4;
      longint           c2, c3, c4, t, n1, n2, n3, n4;
      relaxed_word_type r;
      sat = 1'b0;
      m0 = longint'($signed(d[0*DW +: DW]));
      m1 = longint'($signed(d[1*DW +: DW]));
      m2 = longint'($signed(d[2*DW +: DW]));
      m3 = longint'($signed(d[3*DW +: DW]));
      m4 = longint'($signed(d[4*DW +: DW]));
      e  = longint'($signed(d[5*DW +: DW]));
      z  = (dz > ONE) ? ONE : longint'({47'd0, dz});
      z2 = fx_mul(z, z, sat);
      z3 = fx_mul(z2, z, sat);
      z4 = fx_mul(z3, z, sat);
      a  = fx_mul(e, z - ONE, sat);
      s  = ONE - z2;
      a2 = fx_mul(a, a, sat);
      a3 = fx_mul(a2, a, sat);
      a4 = fx_mul(a3, a, sat);
      c2 = fx_add(a2, s, sat);
      c3 = fx_add(a3, fx_times(fx_mul(a, s, sat), 3, sat), sat);
      c4 = fx_add(a4, fx_times(fx_mul(a2, s, sat), 6, sat), sat);
      c4 = fx_add(c4, fx_times(fx_mul(s, s, sat), 3, sat), sat);
      n1 = fx_add(fx_mul(z, m1, sat), fx_mul(a, m0, sat), sat);
      n2 = fx_mul(z2, m2, sat);
      t  = fx_times(fx_mul(z, a, sat), 2, sat);
      n2 = fx_add(n2, fx_mul(t, m1, sat), sat);
      n2 = fx_add(n2, fx_mul(c2, m0, sat), sat);
      n3 = fx_mul(z3, m3, sat);
      t  = fx_times(fx_mul(z2, a, sat), 3, sat);
      n3 = fx_add(n3, fx_mul(t, m2, sat), sat);
      t  = fx_times(fx_mul(z, c2, sat), 3, sat);
      n3 = fx_add(n3, fx_mul(t, m1, sat), sat);
      n3 = fx_add(n3, fx_mul(c3, m0, sat), sat);
      n4 = fx_mul(z4, m4, sat);
      t  = fx_times(fx_mul(z3, a, sat), 4, sat);
      n4 = fx_add(n4, fx_mul(t, m3, sat), sat);
      t  = fx_times(fx_mul(z2, c2, sat), 6, sat);
      n4 = fx_add(n4, fx_mul(t, m2, sat), sat);
      t  = fx_times(fx_mul(z, c3, sat), 4, sat);
      n4 = fx_add(n4, fx_mul(t, m1, sat), sat);
      n4 = fx_add(n4, fx_mul(c4, m0, sat), sat);
      n1 = fx_clip(n1, sat);
      n2 = fx_clip(n2, sat);
      n3 = fx_clip(n3, sat);
      n4 = fx_clip(n4, sat);
      r.moments = {n4[DW-1:0], n3[DW-1:0], n2[DW-1:0], n1[DW-1:0], m0[DW-1:0]};
      r.sat     = sat;
      return r;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady_mode || roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [DW-1:0] pick_value();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
         2: return 32'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
         default: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      endcase
   endfunction

   function automatic point_word_type pick_point();
      point_word_type p;
      for (int i = 0; i < 6; i++) p[i*DW +: DW] = pick_value();
      return p;
   endfunction

   // mark accepted words and predict their results
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         expected_words.push_back(relax_point(req_tdata, decay_mirror));
         word_taken = 1'b1;
      end
   end

   // drive the request channel from the pending queue
   always @(negedge clock) begin
      bit vld;
      if (!reset && (!req_tvalid || word_taken)) begin
         word_taken = 1'b0;
         vld = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
         end else if (pending_points.size() > 0) begin
            req_tdata <= pending_points.pop_front();
            vld = 1'b1;
            req_gap = pick_gap();
         end
         req_tvalid <= vld;
      end
   end

   // toggle result back-pressure
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) rsp_gap = pick_gap();
         end
      end
   end

   // compare each result word with the oldest prediction
   always @(posedge clock) begin
      relaxed_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected word %h sat %b", $realtime, rsp_tdata, rsp_tuser);
            error_count++;
         end else begin
            want = expected_words.pop_front();
            for (int i = 0; i < 5; i++) begin
               if (rsp_tdata[i*DW +: DW] !== want.moments[i*DW +: DW]) begin
                  $display("%0t: new_moment%0d expected %h actual %h", $realtime, i,
                           want.moments[i*DW +: DW], rsp_tdata[i*DW +: DW]);
                  error_count++;
               end
            end
            if (rsp_tuser[0] !== want.sat) begin
               $display("%0t: saturated expected %b actual %b", $realtime, want.sat,
                        rsp_tuser[0]);
               error_count++;
            end
         end
      end
   end

   task automatic drain_and_load(logic [FB:0] dz);
      wait (pending_points.size() == 0 && !req_tvalid && expected_words.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= dz;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      decay_mirror = dz;
   endtask

   initial begin
      logic [FB:0]    decay_list[8];
      point_word_type p;
      decay_list = '{17'd0, 17'd65536, 17'd131071, 17'd32768, 17'd1, 17'd65535,
                     17'd65537, 17'd60000};
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < 8; ph++) begin
         drain_and_load(ph < 7 ? decay_list[ph] : 17'($urandom_range(0, 131071)));
         steady_mode = (ph == 2 || ph == 5);
         // field and moment extremes at the first settings
         if (ph < 3) begin
            pending_points.push_back('0);
            pending_points.push_back({6{32'h7fff_ffff}});
            pending_points.push_back({6{32'h8000_0000}});
            pending_points.push_back({6{32'h0001_0000}});
            pending_points.push_back({32'h7fff_ffff, {5{32'h0001_0000}}});
            pending_points.push_back({32'h8000_0000, {5{32'hffff_0000}}});
            pending_points.push_back({6{32'hffff_ffff}});
            pending_points.push_back({32'h0002_0000, 128'd0, 32'h0001_0000});
         end
         for (int i = 0; i < 60; i++) begin
            p = pick_point();
            pending_points.push_back(p);
         end
      end
      drain_and_load(17'($urandom_range(0, 131071)));
      for (int i = 0; i < 15; i++) pending_points.push_back(pick_point());

      wait (pending_points.size() == 0 && !req_tvalid && expected_words.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0 && expected_words.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
